// ----- hw/rtl/bda_pkg.sv -----
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package bda_pkg;

	// operand and digit geometry
	localparam int BIN_W      = 32;
	localparam int MAX_DIGITS = 10;
	localparam int BCD_W      = 4 * MAX_DIGITS;
	localparam int CNT_W      = $clog2(BIN_W);
	localparam int REM_W      = $clog2(MAX_DIGITS + 1);
	localparam int HALF_W     = 16;
	localparam int CHAR_W     = 6;

	// character codes, low six bits of ascii
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'(8'h30);
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'(8'h2D);

	// mode codes for func
	localparam logic FUNC_UNSIGNED = 1'b0;
	localparam logic FUNC_SIGNED   = 1'b1;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_SKIP,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic shift;
		logic skip;
		logic emit_sign;
		logic emit_digit;
	} ctrl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic shift_last;
		logic lead_zero;
		logic one_left;
		logic neg;
	} dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bda_ctrl.sv -----
// ----------------------------------------------------------------------------
// bda_ctrl
// Sequencer: load, double-dabble shifts, leading zero skip, character output.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_ctrl
	import bda_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd,
	output logic            busy
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				if (status.shift_last) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// drop leading zero digits, always keep the last one
				if (status.lead_zero && !status.one_left) begin
					cmd.skip = 1'b1;
				end else if (status.neg) begin
					state_d = ST_SIGN;
				end else begin
					state_d = ST_DIGIT;
				end
			end
			ST_SIGN: begin
				cmd.emit_sign = 1'b1;
				state_d       = ST_DIGIT;
			end
			ST_DIGIT: begin
				cmd.emit_digit = 1'b1;
				if (status.one_left) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/bda_dp.sv -----
// ----------------------------------------------------------------------------
// bda_dp
// Datapath: magnitude load, double-dabble BCD conversion, character register.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_dp
	import bda_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctrl_cmd_t         cmd,
	input  wire logic [BIN_W-1:0]  value,
	input  wire logic              func,
	output dp_status_t             status,
	output logic [CHAR_W-1:0]      ascii_char,
	output logic                   last,
	output logic                   strobe
);

	logic [BIN_W-1:0]  bin_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [REM_W-1:0]  rem_q;
	logic              neg_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic              strobe_q;

	logic [BIN_W-1:0]  mag;
	logic              is_neg;
	logic [BCD_W-1:0]  bcd_adj;
	logic [3:0]        top_digit;

	// operand magnitude, signed mode reads the low half as two's complement
	always_comb begin
		is_neg = (func == FUNC_SIGNED) && value[HALF_W-1];
		if (is_neg) begin
			mag = BIN_W'((HALF_W+1)'(1 << HALF_W) - {1'b0, value[HALF_W-1:0]});
		end else if (func == FUNC_SIGNED) begin
			mag = BIN_W'(value[HALF_W-1:0]);
		end else begin
			mag = value;
		end
	end

	// add-3 correction on every digit ahead of the shift
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: 4];

	// conversion registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (cmd.shift) begin
			bin_q <= {bin_q[BIN_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[BIN_W-1]};
		end else if (cmd.skip || cmd.emit_digit) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
		end
	end

	// step and digit counters, sign flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rem_q <= '0;
			neg_q <= 1'b0;
		end else if (cmd.load) begin
			cnt_q <= '0;
			rem_q <= REM_W'(MAX_DIGITS);
			neg_q <= is_neg;
		end else if (cmd.shift) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (cmd.skip || cmd.emit_digit) begin
			rem_q <= rem_q - 1'b1;
		end
	end

	// character output register
	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= CHAR_ZERO + CHAR_W'(top_digit);
			last_q <= (rem_q == REM_W'(1));
		end
	end

	// transfer strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit_sign || cmd.emit_digit;
		end
	end

	assign status.shift_last = (cnt_q == CNT_W'(BIN_W - 1));
	assign status.lead_zero  = (top_digit == 4'd0);
	assign status.one_left   = (rem_q == REM_W'(1));
	assign status.neg        = neg_q;

	assign ascii_char = char_q;
	assign last       = last_q;
	assign strobe     = strobe_q;

endmodule

`default_nettype wire

// ----- hw/rtl/binary_to_decimal_ascii_core.sv -----
// Each number is handled as a load, 32 double-dabble shifts, ten digit steps
// (leading zero skips plus emitted digits), one step leaving the skip loop and,
// for a negative number, a minus sign step; each suppressed leading zero delays
// the first character strobe. One character per cycle once output starts.
// Reset (arst_n low) returns to idle and clears the strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core
// Prints an unsigned 32-bit or signed 16-bit number as decimal ASCII text.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii_core
	import bda_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [BIN_W-1:0]  value,
	input  wire logic              func,
	output logic [CHAR_W-1:0]      ascii_char,
	output logic                   last,
	output logic                   strobe
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// sequencer
	bda_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// conversion datapath
	bda_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.value      (value),
		.func       (func),
		.status     (status),
		.ascii_char (ascii_char),
		.last       (last),
		.strobe     (strobe)
	);

	// at most one datapath command per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("datapath commands overlap");

	// an accepted number keeps the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after start");

	// every transfer is a minus sign or a digit
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (ascii_char == CHAR_MINUS ||
			(ascii_char >= CHAR_ZERO && ascii_char <= CHAR_ZERO + CHAR_W'(9))))
		else $error("character out of range");

	// the final character ends the burst
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |=> !strobe)
		else $error("transfer right after final character");

	// a minus sign is never the final character
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && ascii_char == CHAR_MINUS) |-> !last)
		else $error("minus sign flagged last");

endmodule

`default_nettype wire
